[rtl/core/sorted_table_linear_interpolator_macros.svh]
`ifndef SORTED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define SORTED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// same-cycle implication check
`define STI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interpolator check failed");

// next-cycle implication check
`define STI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interpolator check failed");

`endif

[rtl/core/sti_pkg.sv]
package sti_pkg;

  localparam int Depth  = 64;
  localparam int CountW = 7;
  localparam int ValueW = 32;
  localparam int ProdW  = 2 * ValueW;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_EVAL   = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  typedef struct packed {
    logic                     kind;
    logic signed [ValueW-1:0] x_value;
    logic signed [ValueW-1:0] y_value;
  } req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] result_value;
    logic [1:0]               status;
  } rsp_t;

  typedef struct packed {
    logic              write;
    logic              load;
    logic [ValueW-1:0] key_x;
    logic [ValueW-1:0] key_y;
  } cell_ctl_t;

  typedef struct packed {
    logic first;
    logic active;
    logic tail;
    logic last;
  } cell_pos_t;

  typedef struct packed {
    logic              hit;
    logic [ValueW-1:0] xa;
    logic [ValueW-1:0] ya;
    logic [ValueW-1:0] xb;
    logic [ValueW-1:0] yb;
  } seg_t;

endpackage

[rtl/core/sti_cell.sv]
module sti_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  sti_pkg::cell_ctl_t            ctl,
  input  sti_pkg::cell_pos_t            pos,
  input  logic [sti_pkg::ValueW-1:0]    prev_x,
  input  logic [sti_pkg::ValueW-1:0]    prev_y,
  input  logic                          prev_lt,
  input  logic [sti_pkg::ValueW-1:0]    next_x,
  input  logic [sti_pkg::ValueW-1:0]    next_y,
  input  logic                          next_ge,
  input  logic                          next_last,
  input  sti_pkg::seg_t                 seg_in,
  output logic [sti_pkg::ValueW-1:0]    x_out,
  output logic [sti_pkg::ValueW-1:0]    y_out,
  output logic                          lt,
  output logic                          eq,
  output logic                          ge,
  output sti_pkg::seg_t                 seg_out
);

  logic [sti_pkg::ValueW-1:0] px;
  logic [sti_pkg::ValueW-1:0] py;
  sti_pkg::seg_t              seg;
  logic                       sel;

  assign lt  = pos.active & ($signed(ctl.key_x) < $signed(px));
  assign eq  = pos.active & (ctl.key_x == px);
  assign ge  = pos.active & !lt;
  assign sel = (pos.first & !ge) | (ge & !next_ge & !pos.last) | (next_ge & next_last);

  assign x_out   = px;
  assign y_out   = py;
  assign seg_out = seg;

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      if (prev_lt) begin
        px <= prev_x;
        py <= prev_y;
      end else if (lt | pos.tail) begin
        px <= ctl.key_x;
        py <= ctl.key_y;
      end
    end
  end

  // segment search result walks toward the end of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= '0;
    end else if (ctl.load) begin
      seg.hit <= sel;
      seg.xa  <= px;
      seg.ya  <= py;
      seg.xb  <= next_x;
      seg.yb  <= next_y;
    end else begin
      seg <= seg_in;
    end
  end

endmodule

[rtl/core/sti_div.sv]
module sti_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sti_pkg::ProdW-1:0]     num,
  input  logic [sti_pkg::ValueW-1:0]    den,
  output logic                          done,
  output logic [sti_pkg::ProdW-1:0]     quo
);

  localparam int StepW = $clog2(sti_pkg::ProdW);

  logic [sti_pkg::ProdW-1:0]  acc;
  logic [sti_pkg::ValueW-1:0] rem;
  logic [sti_pkg::ValueW-1:0] dv;
  logic [StepW-1:0]           cnt;
  logic                       running;
  logic [sti_pkg::ValueW+1:0] diff;

  assign diff = {1'b0, rem, acc[sti_pkg::ProdW-1]} - {2'b00, dv};
  assign quo  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == StepW'(sti_pkg::ProdW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      rem <= '0;
      dv  <= den;
    end else if (running) begin
      if (!diff[sti_pkg::ValueW+1]) begin
        rem <= diff[sti_pkg::ValueW-1:0];
      end else begin
        rem <= {rem[sti_pkg::ValueW-2:0], acc[sti_pkg::ProdW-1]};
      end
      acc <= {acc[sti_pkg::ProdW-2:0], !diff[sti_pkg::ValueW+1]};
    end
  end

endmodule

[rtl/core/sorted_table_linear_interpolator.sv]
// Sorted point table with linear interpolation. One request at a time: an insert
// compares in every cell, then shifts in at the edge. An evaluate takes the
// request, marks the bracketing segment in the cell chain, lets that segment walk
// to the chain end (a shorter walk the higher it sits in the table), forms the
// differences and the 32x32 product, runs the one-bit-per-cycle divider (64 steps
// and the done flag), and then adds and saturates.
// Evaluate on an empty or single-point table answers without the segment search. A finished
// response waits in the output register while the next request is taken.
`include "sorted_table_linear_interpolator_macros.svh"

module sorted_table_linear_interpolator (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  sti_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output sti_pkg::rsp_t   rsp
);

  localparam int VW = sti_pkg::ValueW;
  localparam int CW = sti_pkg::CountW;
  localparam int D  = sti_pkg::Depth;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_EV    = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_MAG   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_SUM   = 3'd7;

  logic [2:0]          state;
  logic [CW-1:0]       count;
  sti_pkg::req_t       req_r;
  sti_pkg::cell_ctl_t  ctl;

  logic [VW-1:0]       cx [D];
  logic [VW-1:0]       cy [D];
  logic [D-1:0]        lt;
  logic [D-1:0]        eq;
  logic [D-1:0]        ge;
  logic [D-1:0]        lastv;
  logic [D-1:0]        hits;
  sti_pkg::seg_t       segs [D];

  logic [VW-1:0]       xa, ya, xb, yb;
  logic [VW-1:0]       xmag, ymag, dx;
  logic                qneg;
  logic [sti_pkg::ProdW-1:0] prod;
  logic                div_start, div_done;
  logic [sti_pkg::ProdW-1:0] quo;

  logic                out_free, emit, dup, full;
  sti_pkg::rsp_t       rsp_next;
  logic [VW:0]         xd, yd;
  logic [sti_pkg::ProdW+1:0] qs, sum;

  assign out_free  = !rsp_valid | !rsp_stall;
  assign req_stall = (state != S_IDLE);
  assign dup       = |eq;
  assign full      = (count == CW'(D));

  assign ctl.write = (state == S_INS) & out_free & !dup & !full;
  assign ctl.load  = (state == S_EV) & (count > CW'(1));
  assign ctl.key_x = req_r.x_value;
  assign ctl.key_y = req_r.y_value;

  for (genvar i = 0; i < D; i++) begin : g_cell
    sti_pkg::cell_pos_t pos;
    assign pos.first  = (i == 0);
    assign pos.active = CW'(i) < count;
    assign pos.tail   = CW'(i) == count;
    assign pos.last   = CW'(i + 1) == count;
    assign lastv[i]   = pos.last;
    assign hits[i]    = segs[i].hit;

    sti_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .pos       (pos),
      .prev_x    ((i == 0) ? '0 : cx[(i == 0) ? 0 : i - 1]),
      .prev_y    ((i == 0) ? '0 : cy[(i == 0) ? 0 : i - 1]),
      .prev_lt   ((i == 0) ? 1'b0 : lt[(i == 0) ? 0 : i - 1]),
      .next_x    ((i == D - 1) ? '0 : cx[(i == D - 1) ? i : i + 1]),
      .next_y    ((i == D - 1) ? '0 : cy[(i == D - 1) ? i : i + 1]),
      .next_ge   ((i == D - 1) ? 1'b0 : ge[(i == D - 1) ? i : i + 1]),
      .next_last ((i == D - 1) ? 1'b0 : lastv[(i == D - 1) ? i : i + 1]),
      .seg_in    ((i == 0) ? '0 : segs[(i == 0) ? 0 : i - 1]),
      .x_out     (cx[i]),
      .y_out     (cy[i]),
      .lt        (lt[i]),
      .eq        (eq[i]),
      .ge        (ge[i]),
      .seg_out   (segs[i])
    );
  end

  sti_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (dx),
    .done  (div_done),
    .quo   (quo)
  );

  // xd holds xa - x, so its sign marks x above xa
  assign xd  = {xa[VW-1], xa} - {req_r.x_value[VW-1], req_r.x_value};
  assign yd  = {yb[VW-1], yb} - {ya[VW-1], ya};
  assign prod = {{VW{1'b0}}, xmag} * {{VW{1'b0}}, ymag};
  assign qs  = qneg ? ('0 - {2'b00, quo}) : {2'b00, quo};
  assign sum = {{(sti_pkg::ProdW + 2 - VW){ya[VW-1]}}, ya} + qs;
  assign div_start = (state == S_MUL);

  always_comb begin
    emit     = 1'b0;
    rsp_next = '0;
    case (state)
      S_INS: begin
        emit = out_free;
        if (dup) begin
          rsp_next.status = sti_pkg::ST_DUP;
        end else if (full) begin
          rsp_next.status = sti_pkg::ST_FULL;
        end
      end
      S_EV: begin
        emit = out_free & (count <= CW'(1));
        if (count == CW'(1)) begin
          rsp_next.result_value = cy[0];
        end
      end
      S_SUM: begin
        emit = out_free;
        if (sum[sti_pkg::ProdW+1:VW-1] != '0 && sum[sti_pkg::ProdW+1:VW-1] != '1) begin
          rsp_next.status       = sti_pkg::ST_SAT;
          rsp_next.result_value = sum[sti_pkg::ProdW+1] ? {1'b1, {(VW-1){1'b0}}}
                                                        : {1'b0, {(VW-1){1'b1}}};
        end else begin
          rsp_next.result_value = sum[VW-1:0];
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (ctl.write) begin
        count <= count + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= (req.kind == sti_pkg::KIND_INSERT) ? S_INS : S_EV;
          end
        end
        S_INS: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_EV: begin
          if (count > CW'(1)) begin
            state <= S_SHIFT;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_SHIFT: begin
          if (segs[D-1].hit) begin
            state <= S_MAG;
          end
        end
        S_MAG:   state <= S_MUL;
        S_MUL:   state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_r <= req;
    end
    if (emit) begin
      rsp <= rsp_next;
    end
    if (state == S_SHIFT && segs[D-1].hit) begin
      xa <= segs[D-1].xa;
      ya <= segs[D-1].ya;
      xb <= segs[D-1].xb;
      yb <= segs[D-1].yb;
    end
    if (state == S_MAG) begin
      xmag <= xd[VW] ? VW'('0 - xd) : VW'(xd);
      ymag <= yd[VW] ? VW'('0 - yd) : VW'(yd);
      dx   <= xb - xa;
      qneg <= ($signed(req_r.x_value) < $signed(xa)) != yd[VW];
    end
  end

  `STI_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(D))
  `STI_ASSERT_NOW(a_one_segment, state == S_SHIFT, $onehot0(hits))
  `STI_ASSERT_NEXT(a_count_step, ctl.write, count == $past(count) + 1'b1)
  `STI_ASSERT_NOW(a_no_dup_write, ctl.write, !dup && !full)

endmodule

[tb/sv/sorted_table_linear_interpolator_test.sv]
`timescale 1ns / 100ps

module sorted_table_linear_interpolator_test;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  sti_pkg::req_t  req = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  sti_pkg::rsp_t  rsp;

  sorted_table_linear_interpolator i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // table as the block should hold it
  logic signed [sti_pkg::ValueW-1:0] table_x [sti_pkg::Depth];
  logic signed [sti_pkg::ValueW-1:0] table_y [sti_pkg::Depth];
  int                                table_count = 0;
  sti_pkg::rsp_t                     pending_results [$];

  int error_count = 0;
  int insert_count = 0, eval_count = 0, dup_count = 0, full_count = 0, sat_count = 0;
  int checked_count = 0;

  int  burst_left = 0;
  int  stall_pct = 0;
  logic hold_start = 1'b0;
  logic hold_taken = 1'b0;
  int  hold_cycles = 0;

  function automatic sti_pkg::rsp_t interpolate_table(sti_pkg::req_t r);
    sti_pkg::rsp_t e;
    int pos, last, seg;
    bit dup;
    logic signed [127:0] dx, dy, dd, sum;
    e = '0;
    if (r.kind == sti_pkg::KIND_INSERT) begin
      insert_count++;
      pos = table_count;
      dup = 1'b0;
      for (int i = 0; i < table_count; i++) begin
        if (table_x[i] == r.x_value) begin
          dup = 1'b1;
          break;
        end
        if (r.x_value < table_x[i]) begin
          pos = i;
          break;
        end
      end
      if (dup) begin
        e.status = sti_pkg::ST_DUP;
        dup_count++;
      end else if (table_count >= sti_pkg::Depth) begin
        e.status = sti_pkg::ST_FULL;
        full_count++;
      end else begin
        for (int j = table_count; j > pos; j--) begin
          table_x[j] = table_x[j-1];
          table_y[j] = table_y[j-1];
        end
        table_x[pos] = r.x_value;
        table_y[pos] = r.y_value;
        table_count++;
      end
    end else begin
      eval_count++;
      if (table_count == 1) begin
        e.result_value = table_y[0];
      end else if (table_count >= 2) begin
        last = -1;
        for (int i = 0; i < table_count; i++) begin
          if (r.x_value < table_x[i]) break;
          last = i;
        end
        if (last < 0) seg = 0;
        else if (last >= table_count - 1) seg = table_count - 2;
        else seg = last;
        dx = r.x_value;
        dx = dx - table_x[seg];
        dy = table_y[seg+1];
        dy = dy - table_y[seg];
        dd = table_x[seg+1];
        dd = dd - table_x[seg];
        sum = (dx * dy) / dd;
        sum = sum + table_y[seg];
        if (sum > 128'sd2147483647) begin
          e.result_value = 32'sh7fffffff;
          e.status = sti_pkg::ST_SAT;
        end else if (sum < -128'sd2147483648) begin
          e.result_value = 32'sh80000000;
          e.status = sti_pkg::ST_SAT;
        end else begin
          e.result_value = sum[31:0];
        end
        if (e.status == sti_pkg::ST_SAT) sat_count++;
      end
    end
    return e;
  endfunction

  task automatic send_request(input logic kind, input logic [31:0] x, input logic [31:0] y);
    sti_pkg::req_t r;
    int gap;
    r.kind = kind;
    r.x_value = x;
    r.y_value = y;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 15);
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(3) == 0) gap = 0;
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.push_back(interpolate_table(r));
  endtask

  task automatic stop_sending();
    req_valid <= 1'b0;
    burst_left = 0;
  endtask

  always @(posedge clk) begin
    sti_pkg::rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $error("response with nothing outstanding: result_value %0d status %0d",
               rsp.result_value, rsp.status);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        checked_count++;
        if (rsp.result_value !== e.result_value) begin
          $error("result_value expected %0d actual %0d", e.result_value, rsp.result_value);
          error_count++;
        end
        if (rsp.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, rsp.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_start && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= 400;
      rsp_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [31:0] pick_x();
    int sel;
    logic [31:0] v;
    sel = $urandom_range(99);
    if (table_count > 0 && sel < 15) begin
      v = table_x[$urandom_range(table_count - 1)];
    end else if (table_count > 0 && sel < 30) begin
      v = table_x[$urandom_range(table_count - 1)] + $urandom_range(2) - 1;
    end else if (sel < 60) begin
      v = ($urandom_range(2000) - 1000) * 4096 + $urandom_range(4095);
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic logic [31:0] pick_y();
    if ($urandom_range(1)) return $urandom;
    return ($urandom_range(2000) - 1000) * 1024 + $urandom_range(1023);
  endfunction

  task automatic test_empty_table();
    send_request(sti_pkg::KIND_EVAL, 32'h0, 32'hffffffff);
    send_request(sti_pkg::KIND_EVAL, 32'h7fffffff, 32'h0);
    send_request(sti_pkg::KIND_EVAL, 32'h80000000, 32'h12345678);
  endtask

  task automatic test_single_point();
    send_request(sti_pkg::KIND_INSERT, 32'h0, 32'h7fff0000);
    send_request(sti_pkg::KIND_EVAL, 32'h80000000, 32'h0);
    send_request(sti_pkg::KIND_EVAL, 32'h7fffffff, 32'h0);
    send_request(sti_pkg::KIND_INSERT, 32'h0, 32'h1);
  endtask

  task automatic test_saturation();
    send_request(sti_pkg::KIND_INSERT, 32'h00010000, 32'h7fffffff);
    send_request(sti_pkg::KIND_EVAL, 32'h00008000, 32'h0);
    send_request(sti_pkg::KIND_EVAL, 32'h7fffffff, 32'h0);
    send_request(sti_pkg::KIND_EVAL, 32'h80000000, 32'h0);
    send_request(sti_pkg::KIND_INSERT, 32'h00020000, 32'h80000000);
    send_request(sti_pkg::KIND_EVAL, 32'h7fffffff, 32'h0);
    send_request(sti_pkg::KIND_EVAL, 32'h00018000, 32'h0);
    send_request(sti_pkg::KIND_EVAL, 32'h00020000, 32'h0);
  endtask

  task automatic test_extreme_points();
    send_request(sti_pkg::KIND_INSERT, 32'h80000000, 32'h80000000);
    send_request(sti_pkg::KIND_INSERT, 32'h7fffffff, 32'h7fffffff);
    send_request(sti_pkg::KIND_INSERT, 32'h7fffffff, 32'h0);
    send_request(sti_pkg::KIND_EVAL, 32'h80000000, 32'h0);
    send_request(sti_pkg::KIND_EVAL, 32'h7fffffff, 32'h0);
    send_request(sti_pkg::KIND_EVAL, 32'hc0000000, 32'h0);
    send_request(sti_pkg::KIND_EVAL, 32'h40000000, 32'h0);
    send_request(sti_pkg::KIND_EVAL, 32'hffffffff, 32'h0);
  endtask

  task automatic test_random_mix(input int n, input int pct);
    stall_pct = pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30) send_request(sti_pkg::KIND_INSERT, pick_x(), pick_y());
      else send_request(sti_pkg::KIND_EVAL, pick_x(), pick_y());
    end
  endtask

  task automatic test_full_table();
    while (table_count < sti_pkg::Depth) begin
      send_request(sti_pkg::KIND_INSERT, $urandom, pick_y());
    end
    send_request(sti_pkg::KIND_INSERT, $urandom, $urandom);
    send_request(sti_pkg::KIND_INSERT, table_x[5], $urandom);
    for (int i = 0; i < 20; i++) send_request(sti_pkg::KIND_EVAL, pick_x(), $urandom);
  endtask

  task automatic test_output_hold();
    stall_pct = 0;
    stop_sending();
    @(posedge clk);
    hold_start <= 1'b1;
    burst_left = 1000;
    for (int i = 0; i < 12; i++) send_request(i % 3 == 0, pick_x(), pick_y());
    burst_left = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_single_point();
    test_saturation();
    test_random_mix(250, 30);
    test_output_hold();
    test_random_mix(125, 0);
    test_random_mix(125, 70);
    test_extreme_points();
    test_full_table();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d inserts and %0d evaluates, %0d responses checked",
             insert_count, eval_count, checked_count);
    $display("duplicates %0d, table full %0d, saturated %0d, final table size %0d",
             dup_count, full_count, sat_count, table_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[sorted_table_linear_interpolator.f]
+incdir+rtl/core
rtl/core/sti_pkg.sv
rtl/core/sti_cell.sv
rtl/core/sti_div.sv
rtl/core/sorted_table_linear_interpolator.sv
tb/sv/sorted_table_linear_interpolator_test.sv
